// ===== src/sorted_key_index_table_macros.svh =====
// Assertion helpers for the sorted key/index table.
// Both forms sample on clk_i and are disabled while rst_ni is low.
`ifndef SORTED_KEY_INDEX_TABLE_MACROS_SVH
`define SORTED_KEY_INDEX_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge.
`define SKIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds at any clock edge.
`define SKIT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SKIT_ASSERT(lbl, prop, msg)
`define SKIT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/skit_pkg.sv =====
package skit_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int POS_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Reduction tree: cells per first-level group
  localparam int GROUP_SIZE  = 16;
  localparam int GROUP_COUNT = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int KEY_W  = 64;
  localparam int IDX_W  = 32;
  localparam int IN_W   = 96;
  localparam int OUT_W  = 40;

  // Operation codes carried on the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  // Commands broadcast to every cell
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_CMP    = 3'd1,
    CMD_FILL   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // Broadcast from the sequencer to the cell row
  typedef struct packed {
    cmd_e             op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] sel;
  } cmd_t;

  // Handed from one cell to its right-hand neighbour (eq also to its left-hand one)
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic             eq;
    logic             after;
  } link_t;

  // Per-cell contribution, OR-reduced over the row
  typedef struct packed {
    logic             any_eq;
    logic             dead;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
    logic [IDX_W-1:0] rd_idx;
  } sum_t;

endpackage

// ===== src/sorted_key_index_table.sv =====
// Sorted key/index table.
// Input channel s_axis: tuser carries the operation (add, look up, remove),
// tdata the signed 64-bit key and the 32-bit index stored by an add.
// Output channel m_axis: one transaction per input transaction, carrying the
// looked-up index (0 on a miss or for other operations) and a flag set when
// an add was dropped because the table is full.
// Entries live in a row of cells, one per position; every cell compares its
// key against the broadcast key, and inserts shift the row up by one cell.
// Per-cell flags are OR-reduced through a two-stage registered tree.
// Each operation passes through compare, the two tree levels and a decision;
// a look-up or remove that hits then searches, and a remove zeroes the entry's
// index while a look-up reads the index back through the tree.
// The search steps one probe a cycle, at most log2(entries)+1 probes
// (9 for 256 entries).
// One operation is in flight at a time; the next input is taken the cycle
// after the result enters the output register, even if it is not yet taken.
// A stalled receiver holds the result; the block then waits after finishing
// the following operation. Reset empties the table at once.
`include "sorted_key_index_table_macros.svh"

module sorted_key_index_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [skit_pkg::IN_W-1:0]    s_axis_tdata_i,   // key[63:0], index_value[95:64]
  input  logic [skit_pkg::FUNC_W-1:0]  s_axis_tuser_i,   // func[1:0]
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [skit_pkg::OUT_W-1:0]   m_axis_tdata_o    // found_index[31:0], table_full[32]
);
  import skit_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CMP   = 11'b00000000010,
    S_TREE1 = 11'b00000000100,
    S_TREE2 = 11'b00000001000,
    S_DEC   = 11'b00000010000,
    S_SRCH  = 11'b00000100000,
    S_CLR   = 11'b00001000000,
    S_RD1   = 11'b00010000000,
    S_RD2   = 11'b00100000000,
    S_RD3   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e           state_q, state_d;
  func_e            func_q, func_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] first_q, first_d;
  logic [CNT_W-1:0] last_q, last_d;
  logic [POS_W-1:0] p_q, p_d;
  logic [IDX_W-1:0] res_found_q, res_found_d;
  logic             res_full_q, res_full_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  logic             in_fire;
  logic             out_load;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] run_lo;
  logic [CNT_W-1:0] run_hi;
  cmd_e             cell_op;
  cmd_t             cell_cmd;
  link_t            link [TABLE_DEPTH];
  sum_t             contrib [TABLE_DEPTH];
  sum_t             sum_q;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = state_q == S_IDLE;

  // Probe position and the bounds of the equal-key run
  assign mid_sum = {1'b0, first_q} + {1'b0, last_q};
  assign mid     = mid_sum[CNT_W:1];
  assign run_lo  = CNT_W'(sum_q.first_pos);
  assign run_hi  = CNT_W'(sum_q.last_pos);

  // Sequence one operation through compare, reduce, decide, search and clear or read
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    idx_d       = idx_q;
    count_d     = count_q;
    first_d     = first_q;
    last_d      = last_q;
    p_d         = p_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    out_load    = 1'b0;
    cell_op     = CMD_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          func_d      = func_e'(s_axis_tuser_i);
          key_d       = s_axis_tdata_i[KEY_W-1:0];
          idx_d       = s_axis_tdata_i[KEY_W+IDX_W-1:KEY_W];
          res_found_d = '0;
          res_full_d  = 1'b0;
          state_d     = S_CMP;
        end
      end
      S_CMP: begin
        cell_op = CMD_CMP;
        state_d = S_TREE1;
      end
      S_TREE1: state_d = S_TREE2;
      S_TREE2: state_d = S_DEC;
      S_DEC: begin
        state_d = S_DONE;
        unique case (func_q)
          FUNC_ADD: begin
            priority if (sum_q.dead) begin
              cell_op = CMD_FILL;
            end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
              res_full_d = 1'b1;
            end else begin
              cell_op = CMD_INSERT;
              count_d = count_q + CNT_W'(1);
            end
          end
          FUNC_GET, FUNC_REMOVE: begin
            if (sum_q.any_eq) begin
              first_d = '0;
              last_d  = count_q - CNT_W'(1);
              state_d = S_SRCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_SRCH: begin
        // Replay the probe sequence against the equal run
        priority if (first_q > last_q) begin
          state_d = S_DONE;
        end else if (mid < run_lo) begin
          first_d = mid + CNT_W'(1);
        end else if (mid <= run_hi) begin
          p_d     = mid[POS_W-1:0];
          state_d = (func_q == FUNC_GET) ? S_RD1 : S_CLR;
        end else begin
          last_d = mid - CNT_W'(1);
        end
      end
      S_CLR: begin
        cell_op = CMD_CLEAR;
        state_d = S_DONE;
      end
      S_RD1: state_d = S_RD2;
      S_RD2: state_d = S_RD3;
      S_RD3: begin
        res_found_d = sum_q.rd_idx;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Broadcast the command and the operands to the row
  assign cell_cmd = cmd_t'({cell_op, key_q, idx_q, count_q, p_q});

  // Output register: load on completion, drop once taken
  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {(OUT_W-IDX_W-1)'(0), res_full_q, res_found_q};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      p_q         <= p_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    key_q       <= key_d;
    idx_q       <= idx_d;
    first_q     <= first_d;
    last_q      <= last_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Row of cells, each linked to its left-hand neighbour and to the eq flag of its right-hand one
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    link_t left;
    logic  right_eq;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = link[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_eq = 1'b0;
    end else begin : g_inner
      assign right_eq = link[i+1].eq;
    end

    skit_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pos_i      (POS_W'(i)),
      .cmd_i      (cell_cmd),
      .left_i     (left),
      .right_eq_i (right_eq),
      .link_o     (link[i]),
      .contrib_o  (contrib[i])
    );
  end

  skit_tree u_tree (
    .clk_i     (clk_i),
    .contrib_i (contrib),
    .sum_o     (sum_q)
  );

  `SKIT_NEVER(count_bound_a, count_q > CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `SKIT_ASSERT(full_flag_a,
               (state_q == S_DONE && res_full_q) |-> (count_q == CNT_W'(TABLE_DEPTH)),
               "full flag with free room")
  `SKIT_ASSERT(insert_count_a,
               (state_q == S_DEC && cell_op == CMD_INSERT)
                 |=> (count_q == $past(count_q) + CNT_W'(1)),
               "insert did not grow the table by one")
  `SKIT_ASSERT(clear_pos_a, (state_q == S_CLR) |-> (CNT_W'(p_q) < count_q),
               "remove outside live entries")
  `SKIT_ASSERT(run_order_a,
               (state_q == S_DEC && sum_q.any_eq) |-> (sum_q.first_pos <= sum_q.last_pos),
               "equal-key run out of order")

endmodule

// ===== src/skit_cell.sv =====
module skit_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [skit_pkg::POS_W-1:0] pos_i,
  input  skit_pkg::cmd_t          cmd_i,
  input  skit_pkg::link_t         left_i,
  input  logic                    right_eq_i,
  output skit_pkg::link_t         link_o,
  output skit_pkg::sum_t          contrib_o
);
  import skit_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             gt_q, gt_d;
  logic             eq_q, eq_d;
  logic             live;
  logic             after;
  logic             slot;
  logic             sel_hit;

  // Position lies below the entry count
  assign live    = CNT_W'(pos_i) < cmd_i.count;
  assign after   = !live || gt_q;
  assign slot    = after && !left_i.after;
  assign sel_hit = pos_i == cmd_i.sel;

  // Compare the broadcast key against the stored key
  assign gt_d = live && ($signed(key_q) > $signed(cmd_i.key));
  assign eq_d = live && (key_q == cmd_i.key);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmd_i.op == CMD_CMP) begin
      gt_q <= gt_d;
      eq_q <= eq_d;
    end
  end

  // Fill a dead slot, shift up on insert, clear on remove
  always_comb begin
    key_d = key_q;
    idx_d = idx_q;
    unique case (cmd_i.op)
      CMD_FILL: begin
        if (slot) begin
          key_d = cmd_i.key;
          idx_d = cmd_i.idx;
        end
      end
      CMD_INSERT: begin
        if (after) begin
          if (left_i.after) begin
            key_d = left_i.key;
            idx_d = left_i.idx;
          end else begin
            key_d = cmd_i.key;
            idx_d = cmd_i.idx;
          end
        end
      end
      CMD_CLEAR: begin
        if (sel_hit) begin
          idx_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    idx_q <= idx_d;
  end

  // Hand contents and flags to the right-hand neighbour, and eq to the left-hand one
  assign link_o.key   = key_q;
  assign link_o.idx   = idx_q;
  assign link_o.eq    = eq_q;
  assign link_o.after = after;

  // Mark the edges of the equal run, the dead insertion slot and the read
  assign contrib_o.any_eq    = eq_q;
  assign contrib_o.dead      = slot && live && (idx_q == '0);
  assign contrib_o.first_pos = (eq_q && !left_i.eq) ? pos_i : '0;
  assign contrib_o.last_pos  = (eq_q && !right_eq_i) ? pos_i : '0;
  assign contrib_o.rd_idx    = sel_hit ? idx_q : '0;

endmodule

// ===== src/skit_tree.sv =====
module skit_tree (
  input  logic           clk_i,
  input  skit_pkg::sum_t contrib_i [skit_pkg::TABLE_DEPTH],
  output skit_pkg::sum_t sum_o
);
  import skit_pkg::*;

  sum_t grp_q [GROUP_COUNT];
  sum_t grp_d [GROUP_COUNT];
  sum_t sum_q, sum_d;

  // First level: OR each group of cells
  for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_grp
    localparam int Lo = g * GROUP_SIZE;
    localparam int Hi = (Lo + GROUP_SIZE > TABLE_DEPTH) ? TABLE_DEPTH : Lo + GROUP_SIZE;

    always_comb begin
      grp_d[g] = '0;
      for (int k = Lo; k < Hi; k++) begin
        grp_d[g] = sum_t'(grp_d[g] | contrib_i[k]);
      end
    end

    always_ff @(posedge clk_i) begin
      grp_q[g] <= grp_d[g];
    end
  end

  // Second level: OR the group results
  always_comb begin
    sum_d = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      sum_d = sum_t'(sum_d | grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule
